FILE: sv/sdrm_pkg.sv
// Shared types and constants for the score difference ranking unit.
package sdrm_pkg;

  localparam int MEAN_W    = 32;
  localparam int SPREAD_W  = 31;
  localparam int SUM_W     = 32;
  localparam int DIFF_W    = 33;
  localparam int SCORE_W   = 32;
  localparam int INDEX_W   = 6;
  localparam int IN_DATA_W = 128;
  localparam int OUT_DATA_W = 40;

  // One quotient bit per step, bits 32 down to 0.
  localparam int DIV_STEPS = 33;

  localparam logic [DIFF_W-1:0]  POS_LIMIT = 33'h0_7FFF_FFFF;
  localparam logic [DIFF_W-1:0]  NEG_LIMIT = 33'h0_8000_0000;
  localparam logic [SCORE_W-1:0] POS_SAT   = 32'h7FFF_FFFF;
  localparam logic [SCORE_W-1:0] NEG_SAT   = 32'h8000_0000;

  typedef struct packed {
    logic [1:0]          pad;
    logic [SPREAD_W-1:0] spread_second;
    logic [MEAN_W-1:0]   mean_second;
    logic [SPREAD_W-1:0] spread_first;
    logic [MEAN_W-1:0]   mean_first;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         pad;
    logic [SCORE_W-1:0] score;
    logic [INDEX_W-1:0] entry_index;
  } out_item_t;

endpackage

FILE: sv/score_difference_rank_by_magnitude_unit.sv
// Score difference ranking unit: scores paired estimates and emits them ranked by magnitude.
// Each input transfer takes one item. A stored item passes two setup states (S_PREP, S_CHECK),
// then a restoring divider that yields one quotient bit per cycle, bits 32 down to 0, then the
// write into the score memory; an item whose spread sum is not above spread_floor, or whose
// score saturates, skips the divider; an item beyond MAX_ENTRIES is dropped. No item is taken
// while emission runs. On the item marked last, the block ranks the load by repeated passes
// over the score memory through its single read port: each result costs one pass over the
// loaded entries plus a decision state, and a pass that finds nothing ends the run.
// The result register lets one result wait on out_tready while the next pass runs. out_tlast
// marks the final result of a run; a run in which no entry passes score_floor gives no result.
module score_difference_rank_by_magnitude_unit #(
  parameter int MAX_ENTRIES = 64
) (
  input  logic         clk,
  input  logic         rst_n,
  // in_tdata: mean_first[31:0], spread_first[62:32], mean_second[94:63],
  // spread_second[125:95], zero pad[127:126]
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [127:0] in_tdata,
  input  logic         in_tlast,
  // out_tdata: entry_index[5:0], score[37:6], zero pad[39:38]; out_tlast marks the final result
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [39:0]  out_tdata,
  output logic         out_tlast,
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [2:0]   cfg_paddr,
  input  logic [31:0]  cfg_pwdata,
  output logic [31:0]  cfg_prdata,
  output logic         cfg_pready
);

  localparam int IDX_W = $clog2(MAX_ENTRIES);
  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(MAX_ENTRIES);
  localparam logic [5:0] LAST_STEP = 6'(sdrm_pkg::DIV_STEPS - 1);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_PREP   = 3'd1;
  localparam logic [2:0] S_CHECK  = 3'd2;
  localparam logic [2:0] S_DIV    = 3'd3;
  localparam logic [2:0] S_WRITE  = 3'd4;
  localparam logic [2:0] S_SCAN   = 3'd5;
  localparam logic [2:0] S_DECIDE = 3'd6;

  sdrm_pkg::in_item_t  in_item;
  sdrm_pkg::out_item_t out_item;

  // control
  logic [2:0]             state_r, state_nxt;
  logic [CNT_W-1:0]       count_r, count_nxt;
  logic                   last_r, last_nxt;
  logic [MAX_ENTRIES-1:0] taken_r, taken_nxt;
  logic [CNT_W-1:0]       rd_idx_r, rd_idx_nxt;
  logic                   rd_vld_r, rd_vld_nxt;
  logic                   found_r, found_nxt;
  logic                   pend_vld_r, pend_vld_nxt;
  logic                   out_vld_r, out_vld_nxt;
  logic [31:0]            spread_floor_r, spread_floor_nxt;
  logic [30:0]            score_floor_r, score_floor_nxt;

  // datapath
  logic [32:0]      diff_r, diff_nxt;
  logic [31:0]      sum_r, sum_nxt;
  logic [32:0]      mag_r, mag_nxt;
  logic             neg_r, neg_nxt;
  logic             zero_r, zero_nxt;
  logic             sat_r, sat_nxt;
  logic [31:0]      rem_r, rem_nxt;
  logic [32:0]      num_r, num_nxt;
  logic [32:0]      quo_r, quo_nxt;
  logic [5:0]       step_r, step_nxt;
  logic [IDX_W-1:0] rd_pos_r, rd_pos_nxt;
  logic [IDX_W-1:0] best_idx_r, best_idx_nxt;
  logic [31:0]      best_mag_r, best_mag_nxt;
  logic [31:0]      best_score_r, best_score_nxt;
  logic [IDX_W-1:0] pend_idx_r, pend_idx_nxt;
  logic [31:0]      pend_score_r, pend_score_nxt;
  logic [IDX_W-1:0] out_idx_r, out_idx_nxt;
  logic [31:0]      out_score_r, out_score_nxt;
  logic             out_last_r, out_last_nxt;

  // score memory
  logic [31:0]      score_mem [MAX_ENTRIES];
  logic [31:0]      rdata_r;
  logic             mem_we;
  logic [31:0]      mem_wdata;
  logic [IDX_W-1:0] mem_raddr;

  logic        cfg_wr;
  logic [32:0] div_trial;
  logic        div_ge;
  logic [32:0] div_diff;
  logic [31:0] rd_mag;
  logic        slot_free;
  logic [31:0] score_mag;

  assign in_item   = sdrm_pkg::in_item_t'(in_tdata);
  assign in_tready = (state_r == S_IDLE);

  assign out_item.pad         = '0;
  assign out_item.score       = out_score_r;
  assign out_item.entry_index = sdrm_pkg::INDEX_W'(out_idx_r);
  assign out_tdata  = out_item;
  assign out_tvalid = out_vld_r;
  assign out_tlast  = out_last_r;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_prdata = cfg_paddr[2] ? {1'b0, score_floor_r} : spread_floor_r;

  // restoring division step
  assign div_trial = {rem_r, num_r[32]};
  assign div_ge    = (div_trial >= {1'b0, sum_r});
  assign div_diff  = div_trial - {1'b0, sum_r};

  assign rd_mag    = rdata_r[31] ? (32'd0 - rdata_r) : rdata_r;
  assign slot_free = !out_vld_r || out_tready;
  assign mem_raddr = rd_idx_r[IDX_W-1:0];

  always_comb begin
    if (neg_r) begin
      score_mag = (sat_r || quo_r > sdrm_pkg::NEG_LIMIT) ? sdrm_pkg::NEG_SAT : quo_r[31:0];
      mem_wdata = 32'd0 - score_mag;
    end else begin
      score_mag = (sat_r || quo_r > sdrm_pkg::POS_LIMIT) ? sdrm_pkg::POS_SAT : quo_r[31:0];
      mem_wdata = score_mag;
    end
    if (zero_r) begin
      mem_wdata = '0;
    end
  end

  always_comb begin
    state_nxt        = state_r;
    count_nxt        = count_r;
    last_nxt         = last_r;
    taken_nxt        = taken_r;
    rd_idx_nxt       = rd_idx_r;
    rd_vld_nxt       = rd_vld_r;
    found_nxt        = found_r;
    pend_vld_nxt     = pend_vld_r;
    out_vld_nxt      = out_vld_r && !out_tready;
    spread_floor_nxt = spread_floor_r;
    score_floor_nxt  = score_floor_r;
    diff_nxt         = diff_r;
    sum_nxt          = sum_r;
    mag_nxt          = mag_r;
    neg_nxt          = neg_r;
    zero_nxt         = zero_r;
    sat_nxt          = sat_r;
    rem_nxt          = rem_r;
    num_nxt          = num_r;
    quo_nxt          = quo_r;
    step_nxt         = step_r;
    rd_pos_nxt       = rd_pos_r;
    best_idx_nxt     = best_idx_r;
    best_mag_nxt     = best_mag_r;
    best_score_nxt   = best_score_r;
    pend_idx_nxt     = pend_idx_r;
    pend_score_nxt   = pend_score_r;
    out_idx_nxt      = out_idx_r;
    out_score_nxt    = out_score_r;
    out_last_nxt     = out_last_r;
    mem_we           = 1'b0;

    if (cfg_wr) begin
      if (cfg_paddr[2]) begin
        score_floor_nxt = cfg_pwdata[30:0];
      end else begin
        spread_floor_nxt = cfg_pwdata;
      end
    end

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          diff_nxt = {in_item.mean_first[31], in_item.mean_first}
                   - {in_item.mean_second[31], in_item.mean_second};
          sum_nxt  = {1'b0, in_item.spread_first} + {1'b0, in_item.spread_second};
          last_nxt = in_tlast;
          if (count_r < CNT_FULL) begin
            state_nxt = S_PREP;
          end else if (in_tlast) begin
            // load is full: item dropped, but its last mark still starts the ranking
            taken_nxt    = '0;
            pend_vld_nxt = 1'b0;
            rd_idx_nxt   = '0;
            rd_vld_nxt   = 1'b0;
            found_nxt    = 1'b0;
            state_nxt    = S_SCAN;
          end
        end
      end
      S_PREP: begin
        neg_nxt   = diff_r[32];
        mag_nxt   = diff_r[32] ? (33'd0 - diff_r) : diff_r;
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        // numerator is mag << 17; its bits above 32 seed the remainder
        zero_nxt  = !(sum_r > spread_floor_r);
        sat_nxt   = ({15'd0, mag_r[32:16]} >= sum_r);
        rem_nxt   = {15'd0, mag_r[32:16]};
        num_nxt   = {mag_r[15:0], 17'd0};
        quo_nxt   = '0;
        step_nxt  = '0;
        if (zero_nxt || sat_nxt) begin
          state_nxt = S_WRITE;
        end else begin
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        rem_nxt  = div_ge ? div_diff[31:0] : div_trial[31:0];
        quo_nxt  = {quo_r[31:0], div_ge};
        num_nxt  = {num_r[31:0], 1'b0};
        step_nxt = step_r + 6'd1;
        if (step_r == LAST_STEP) begin
          state_nxt = S_WRITE;
        end
      end
      S_WRITE: begin
        mem_we    = 1'b1;
        count_nxt = count_r + CNT_W'(1);
        if (last_r) begin
          taken_nxt    = '0;
          pend_vld_nxt = 1'b0;
          rd_idx_nxt   = '0;
          rd_vld_nxt   = 1'b0;
          found_nxt    = 1'b0;
          state_nxt    = S_SCAN;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_SCAN: begin
        if (rd_idx_r != count_r) begin
          rd_idx_nxt = rd_idx_r + CNT_W'(1);
          rd_vld_nxt = 1'b1;
          rd_pos_nxt = rd_idx_r[IDX_W-1:0];
        end else begin
          rd_vld_nxt = 1'b0;
        end
        // strict compare keeps the lower index on equal magnitudes
        if (rd_vld_r && !taken_r[rd_pos_r] && (rd_mag > {1'b0, score_floor_r})
            && (!found_r || rd_mag > best_mag_r)) begin
          found_nxt      = 1'b1;
          best_idx_nxt   = rd_pos_r;
          best_mag_nxt   = rd_mag;
          best_score_nxt = rdata_r;
        end
        if (rd_idx_r == count_r && !rd_vld_r) begin
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (found_r) begin
          if (!pend_vld_r || slot_free) begin
            if (pend_vld_r) begin
              out_vld_nxt   = 1'b1;
              out_idx_nxt   = pend_idx_r;
              out_score_nxt = pend_score_r;
              out_last_nxt  = 1'b0;
            end
            pend_vld_nxt            = 1'b1;
            pend_idx_nxt            = best_idx_r;
            pend_score_nxt          = best_score_r;
            taken_nxt[best_idx_r]   = 1'b1;
            rd_idx_nxt              = '0;
            rd_vld_nxt              = 1'b0;
            found_nxt               = 1'b0;
            state_nxt               = S_SCAN;
          end
        end else if (!pend_vld_r) begin
          count_nxt = '0;
          state_nxt = S_IDLE;
        end else if (slot_free) begin
          out_vld_nxt   = 1'b1;
          out_idx_nxt   = pend_idx_r;
          out_score_nxt = pend_score_r;
          out_last_nxt  = 1'b1;
          pend_vld_nxt  = 1'b0;
          count_nxt     = '0;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      count_r        <= '0;
      last_r         <= 1'b0;
      taken_r        <= '0;
      rd_idx_r       <= '0;
      rd_vld_r       <= 1'b0;
      found_r        <= 1'b0;
      pend_vld_r     <= 1'b0;
      out_vld_r      <= 1'b0;
      spread_floor_r <= '0;
      score_floor_r  <= '0;
    end else begin
      state_r        <= state_nxt;
      count_r        <= count_nxt;
      last_r         <= last_nxt;
      taken_r        <= taken_nxt;
      rd_idx_r       <= rd_idx_nxt;
      rd_vld_r       <= rd_vld_nxt;
      found_r        <= found_nxt;
      pend_vld_r     <= pend_vld_nxt;
      out_vld_r      <= out_vld_nxt;
      spread_floor_r <= spread_floor_nxt;
      score_floor_r  <= score_floor_nxt;
    end
  end

  always_ff @(posedge clk) begin
    diff_r       <= diff_nxt;
    sum_r        <= sum_nxt;
    mag_r        <= mag_nxt;
    neg_r        <= neg_nxt;
    zero_r       <= zero_nxt;
    sat_r        <= sat_nxt;
    rem_r        <= rem_nxt;
    num_r        <= num_nxt;
    quo_r        <= quo_nxt;
    step_r       <= step_nxt;
    rd_pos_r     <= rd_pos_nxt;
    best_idx_r   <= best_idx_nxt;
    best_mag_r   <= best_mag_nxt;
    best_score_r <= best_score_nxt;
    pend_idx_r   <= pend_idx_nxt;
    pend_score_r <= pend_score_nxt;
    out_idx_r    <= out_idx_nxt;
    out_score_r  <= out_score_nxt;
    out_last_r   <= out_last_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      score_mem[count_r[IDX_W-1:0]] <= mem_wdata;
    end
    rdata_r <= score_mem[mem_raddr];
  end

endmodule

FILE: bench/tb_score_difference_rank_by_magnitude_unit.sv
// Self-checking testbench for the score difference ranking unit.
module tb_score_difference_rank_by_magnitude_unit;

  localparam int CAPACITY = 64;
  localparam int DRAIN_CYCLES = 200;
  localparam int IDLE_LIMIT = 3000;
  localparam int PHASE_ITEMS = 55;
  localparam logic [2:0] SPREAD_FLOOR_ADDR = 3'd0;
  localparam logic [2:0] SCORE_FLOOR_ADDR = 3'd4;

  typedef struct {
    logic [sdrm_pkg::INDEX_W-1:0] index;
    logic [sdrm_pkg::SCORE_W-1:0] score;
    bit                           fin;
  } ranked_entry_t;

  // Tracks the load, the two floors and the ranked results still owed.
  class score_rank_board;
    logic [31:0] spread_floor_q;
    logic [30:0] score_floor_q;
    logic [31:0] stored[CAPACITY];
    int unsigned stored_count;
    ranked_entry_t expected_ranks[$];
    int unsigned fails;

    function new();
      spread_floor_q = '0;
      score_floor_q = '0;
      stored_count = 0;
      fails = 0;
    endfunction

    task report(string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      fails++;
    endtask

    function void set_register(logic [2:0] addr, logic [31:0] value);
      case (addr)
        SPREAD_FLOOR_ADDR: spread_floor_q = value;
        SCORE_FLOOR_ADDR: score_floor_q = value[30:0];
        default: ;
      endcase
    endfunction

    function logic [31:0] register_value(logic [2:0] addr);
      case (addr)
        SPREAD_FLOOR_ADDR: return spread_floor_q;
        SCORE_FLOOR_ADDR: return {1'b0, score_floor_q};
        default: return '0;
      endcase
    endfunction

    function logic [31:0] score_of(sdrm_pkg::in_item_t it);
      logic [32:0] diff;
      logic [32:0] mag;
      logic [32:0] sum;
      logic [63:0] quo;
      diff = {it.mean_first[31], it.mean_first} - {it.mean_second[31], it.mean_second};
      sum = {2'b00, it.spread_first} + {2'b00, it.spread_second};
      if (sum <= {1'b0, spread_floor_q} || sum == '0) return '0;
      mag = diff[32] ? (~diff + 33'd1) : diff;
      quo = {14'd0, mag, 17'd0} / {31'd0, sum};
      if (diff[32]) begin
        if (quo > 64'h8000_0000) quo = 64'h8000_0000;
        return ~quo[31:0] + 32'd1;
      end
      if (quo > 64'h7FFF_FFFF) quo = 64'h7FFF_FFFF;
      return quo[31:0];
    endfunction

    function logic [31:0] magnitude_of(logic [31:0] s);
      return s[31] ? (~s + 32'd1) : s;
    endfunction

    // Stores the score; on the last item ranks the load and clears it.
    function void note_item(sdrm_pkg::in_item_t it, bit last);
      logic [CAPACITY-1:0] taken;
      logic [31:0] m;
      logic [31:0] best_mag;
      int best;
      int n;
      bit found;
      ranked_entry_t e;
      if (stored_count < CAPACITY) begin
        stored[stored_count] = score_of(it);
        stored_count++;
      end
      if (!last) return;
      taken = '0;
      n = 0;
      do begin
        found = 0;
        best = 0;
        best_mag = '0;
        for (int i = 0; i < stored_count; i++) begin
          if (taken[i]) continue;
          m = magnitude_of(stored[i]);
          // strict compare keeps the lower index on equal magnitudes
          if (m > {1'b0, score_floor_q} && (!found || m > best_mag)) begin
            found = 1;
            best = i;
            best_mag = m;
          end
        end
        if (found) begin
          taken[best] = 1'b1;
          e.index = best[sdrm_pkg::INDEX_W-1:0];
          e.score = stored[best];
          e.fin = 0;
          expected_ranks.push_back(e);
          n++;
        end
      end while (found);
      if (n > 0) expected_ranks[expected_ranks.size()-1].fin = 1;
      stored_count = 0;
    endfunction

    task check_ranked(sdrm_pkg::out_item_t got, bit fin);
      ranked_entry_t e;
      if (expected_ranks.size() == 0) begin
        report($sformatf("unexpected result index %0d score %h", got.entry_index, got.score));
        return;
      end
      e = expected_ranks.pop_front();
      if (got.entry_index != e.index)
        report($sformatf("entry_index got %0d want %0d", got.entry_index, e.index));
      if (got.score != e.score)
        report($sformatf("score of index %0d got %h want %h", e.index, got.score, e.score));
      if (fin != e.fin)
        report($sformatf("final flag of index %0d got %0d want %0d", e.index, fin, e.fin));
    endtask
  endclass

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [127:0] in_tdata;
  logic         in_tlast;
  logic         out_tvalid;
  logic         out_tready;
  logic [39:0]  out_tdata;
  logic         out_tlast;
  logic         cfg_psel;
  logic         cfg_penable;
  logic         cfg_pwrite;
  logic [2:0]   cfg_paddr;
  logic [31:0]  cfg_pwdata;
  logic [31:0]  cfg_prdata;
  logic         cfg_pready;

  score_rank_board book = new();
  bit in_calm;
  bit out_calm;
  sdrm_pkg::in_item_t prev_item;

  score_difference_rank_by_magnitude_unit #(
    .MAX_ENTRIES(CAPACITY)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .in_tlast(in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata),
    .out_tlast(out_tlast),
    .cfg_psel(cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr),
    .cfg_pwdata(cfg_pwdata),
    .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic int pause_len(bit calm);
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 88) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic sdrm_pkg::in_item_t pair_of(logic [31:0] mf, logic [31:0] sf,
                                                 logic [31:0] ms, logic [31:0] ss);
    sdrm_pkg::in_item_t it;
    it = '0;
    it.mean_first = mf;
    it.spread_first = sf[30:0];
    it.mean_second = ms;
    it.spread_second = ss[30:0];
    return it;
  endfunction

  function automatic logic [31:0] extreme_mean();
    case ($urandom_range(0, 3))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'h0000_0000;
      default: return 32'hFFFF_FFFF;
    endcase
  endfunction

  function automatic sdrm_pkg::in_item_t random_item();
    sdrm_pkg::in_item_t it;
    int unsigned r;
    logic [31:0] delta;
    it = '0;
    r = $urandom_range(0, 99);
    if (r < 20) begin
      it = pair_of($urandom, $urandom, $urandom, $urandom);
    end else if (r < 60) begin
      // close means and modest spreads give scores in a useful range
      delta = $urandom_range(0, 1 << 21) - (1 << 20);
      it.mean_first = $urandom;
      it.mean_second = it.mean_first + delta;
      it.spread_first = 31'($urandom_range(1 << 12, 1 << 18));
      it.spread_second = 31'($urandom_range(1 << 12, 1 << 18));
    end else if (r < 75) begin
      // swapped means: equal magnitude, opposite sign
      it = prev_item;
      it.mean_first = prev_item.mean_second;
      it.mean_second = prev_item.mean_first;
    end else if (r < 85) begin
      it = pair_of($urandom, $urandom_range(0, 1), $urandom, $urandom_range(0, 1));
    end else begin
      it = pair_of(extreme_mean(), $urandom_range(0, 1) ? 32'h7FFF_FFFF : $urandom,
                   extreme_mean(), $urandom_range(0, 1) ? 32'h0 : $urandom);
    end
    prev_item = it;
    return it;
  endfunction

  task automatic send_item(sdrm_pkg::in_item_t it, bit last);
    int gap;
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata <= it;
    in_tlast <= last;
    do @(posedge clk); while (!in_tready);
    book.note_item(it, last);
    gap = pause_len(in_calm);
    if (gap > 0) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic send_load(int len);
    in_calm = ($urandom_range(0, 3) == 0);
    out_calm = ($urandom_range(0, 3) == 0);
    for (int k = 0; k < len; k++) send_item(random_item(), k == len - 1);
  endtask

  // Write one register, then read it back.
  task automatic write_floor(logic [2:0] addr, logic [31:0] value);
    logic [31:0] readback;
    @(negedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= addr;
    cfg_pwdata <= value;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    book.set_register(addr, value);
    @(negedge clk);
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    readback = cfg_prdata;
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    if (readback != book.register_value(addr))
      book.report($sformatf("register at %0d read %h want %h", addr, readback,
                            book.register_value(addr)));
  endtask

  task automatic set_floors(logic [31:0] spread, logic [31:0] score);
    write_floor(SPREAD_FLOOR_ADDR, spread);
    write_floor(SCORE_FLOOR_ADDR, score);
  endtask

  // Wait until all results are in and an empty ranking pass has had time to finish.
  task automatic settle();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (book.expected_ranks.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    int n;
    out_tready = 1'b0;
    @(negedge clk);
    forever begin
      out_tready <= 1'b1;
      n = pause_len(out_calm);
      @(negedge clk);
      repeat (n) begin
        out_tready <= 1'b0;
        @(negedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) book.check_ranked(out_tdata, out_tlast);
  end

  initial begin
    int idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_psel && cfg_penable))
        idle = 0;
      else
        idle++;
    end
    $display("score_difference_rank_by_magnitude_unit regression: fail");
    $finish;
  end

  initial begin
    logic [31:0] spread_set[6];
    logic [31:0] score_set[6];
    int sent;
    int len;
    bit overflow_done;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tlast = 1'b0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    in_calm = 1'b0;
    out_calm = 1'b0;
    prev_item = '0;
    overflow_done = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // saturation both ways, zero spread sums, sign ties, duplicate ties
    set_floors(32'h0, 32'h0);
    send_item(pair_of(32'h7FFF_FFFF, 32'h0, 32'h8000_0000, 32'h1), 0);
    send_item(pair_of(32'h8000_0000, 32'h1, 32'h7FFF_FFFF, 32'h0), 0);
    send_item(pair_of(32'h0, 32'h7FFF_FFFF, 32'h0, 32'h7FFF_FFFF), 0);
    send_item(pair_of(32'h1234_5678, 32'h0, 32'hFEDC_BA98, 32'h0), 0);
    send_item(pair_of(32'h0001_0000, 32'h0001_0000, 32'h0, 32'h0001_0000), 0);
    send_item(pair_of(32'h0, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000), 0);
    send_item(pair_of(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF), 0);
    send_item(pair_of(32'h0001_0000, 32'h0001_0000, 32'h0, 32'h0001_0000), 1);
    settle();

    // spread sum and score at the floors give nothing; a second load passes both
    set_floors(32'h0002_0000, 32'h0002_0000);
    send_item(pair_of(32'h0005_0000, 32'h0001_0000, 32'h0, 32'h0001_0000), 0);
    send_item(pair_of(32'h0002_0001, 32'h0001_0000, 32'h0, 32'h0001_0001), 0);
    send_item(pair_of(32'h0004_0000, 32'h0, 32'h0, 32'h0), 1);
    settle();
    send_item(pair_of(32'h0003_0000, 32'h0001_0001, 32'h0, 32'h0001_0001), 1);
    settle();

    set_floors(32'hFFFF_FFFF, 32'h7FFF_FFFF);
    send_item(pair_of(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF), 0);
    send_item(pair_of(32'h8000_0000, 32'h0, 32'h7FFF_FFFF, 32'h1), 1);
    settle();

    spread_set[0] = 32'h0;         score_set[0] = 32'h0;
    spread_set[1] = 32'h0;         score_set[1] = 32'h7FFF_FFFF;
    spread_set[2] = 32'hFFFF_FFFF; score_set[2] = 32'h0;
    spread_set[3] = $urandom_range(0, 1 << 18);
    score_set[3] = $urandom_range(0, 1 << 19);
    spread_set[4] = $urandom_range(0, 1 << 18);
    score_set[4] = $urandom_range(0, 1 << 19);
    spread_set[5] = $urandom;
    score_set[5] = $urandom & 32'h7FFF_FFFF;

    for (int p = 0; p < 6; p++) begin
      set_floors(spread_set[p], score_set[p]);
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        if (!overflow_done) begin
          // more items than slots; the extras are dropped
          len = CAPACITY + $urandom_range(1, 4);
          overflow_done = 1;
        end else if ($urandom_range(0, 99) < 85) begin
          len = $urandom_range(1, 10);
        end else begin
          len = $urandom_range(11, 30);
        end
        send_load(len);
        sent += len;
      end
      settle();
    end

    if (book.fails == 0)
      $display("score_difference_rank_by_magnitude_unit regression: pass");
    else
      $display("score_difference_rank_by_magnitude_unit regression: fail");
    $finish;
  end

endmodule
